[design/jmsc_pkg.sv]
// Shared types, marker codes and verdict codes for the JPEG marker stream checker.
// No dependencies; every other design file but jmsc_checker refers to this package by scoped names.
package jmsc_pkg;

  localparam logic [7:0] BYTE_FF   = 8'hff;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] CODE_TEM  = 8'h01;
  localparam logic [7:0] CODE_SOI  = 8'hd8;
  localparam logic [7:0] CODE_EOI  = 8'hd9;
  localparam logic [7:0] CODE_SOS  = 8'hda;
  localparam logic [7:0] CODE_RST0 = 8'hd0;
  localparam logic [7:0] CODE_RST7 = 8'hd7;

  localparam logic [1:0] VERDICT_GOOD  = 2'd0;
  localparam logic [1:0] VERDICT_BAD   = 2'd1;
  localparam logic [1:0] VERDICT_SHORT = 2'd2;
  localparam logic [1:0] VERDICT_EXTRA = 2'd3;

  typedef enum logic [9:0] {
    PH_PREFIX  = 10'b00_0000_0001,
    PH_CODE    = 10'b00_0000_0010,
    PH_LEN_HI  = 10'b00_0000_0100,
    PH_LEN_LO  = 10'b00_0000_1000,
    PH_SKIP    = 10'b00_0001_0000,
    PH_ENTROPY = 10'b00_0010_0000,
    PH_ENT_FF  = 10'b00_0100_0000,
    PH_FILL    = 10'b00_1000_0000,
    PH_SKIPALL = 10'b01_0000_0000,
    PH_DONE    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] verdict;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  function automatic logic is_rst_code(input logic [7:0] c);
    is_rst_code = (c >= CODE_RST0) && (c <= CODE_RST7);
  endfunction

  function automatic logic [1:0] judge_tail(input logic [7:0] hi, input logic [7:0] lo);
    if (hi != BYTE_FF) begin
      judge_tail = VERDICT_BAD;
    end else if (lo == BYTE_ZERO || is_rst_code(lo)) begin
      judge_tail = VERDICT_BAD;
    end else if (lo == CODE_EOI) begin
      judge_tail = VERDICT_GOOD;
    end else begin
      judge_tail = VERDICT_SHORT;
    end
  endfunction

endpackage

[design/jmsc_in_reg.sv]
// Input register stage of the JPEG marker stream checker.
// Depends on jmsc_pkg for the request type.
module jmsc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  jmsc_pkg::item_t in_item,
  input  logic           adv,
  output logic           s1_valid,
  output jmsc_pkg::item_t s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  jmsc_pkg::item_t item_r;

  assign in_stall = valid_r && !adv;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[design/jmsc_parser.sv]
// Marker walker of the JPEG marker stream checker: per-file state and one-byte step.
// Depends on jmsc_pkg for phases, marker codes, verdict codes and result type.
module jmsc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  jmsc_pkg::item_t  s1_item,
  input  logic             skip_entropy,
  output jmsc_pkg::result_t res
);

  typedef struct packed {
    logic                have_v;
    logic [1:0]          verdict;
    jmsc_pkg::phase_t    phase;
    logic                in_scan;
    logic                enter_skip;
  } code_res_t;

  jmsc_pkg::phase_t phase_r, phase_nxt;
  logic             in_scan_r, in_scan_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [15:0]      skip_left_r, skip_left_nxt;
  logic [7:0]       prev_r, prev_nxt;

  logic [7:0]  b;
  logic        last;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic [7:0]  tail_hi;
  logic [7:0]  tail_lo;
  code_res_t   cr;
  logic        cr_used;
  logic        have_v;
  logic [1:0]  verdict;

  function automatic code_res_t on_code(input logic [7:0] c, input logic lst,
                                        input logic skip, input logic scan);
    code_res_t r;
    r.have_v     = 1'b0;
    r.verdict    = jmsc_pkg::VERDICT_GOOD;
    r.phase      = jmsc_pkg::PH_LEN_HI;
    r.in_scan    = scan;
    r.enter_skip = 1'b0;
    if (c == jmsc_pkg::BYTE_ZERO || jmsc_pkg::is_rst_code(c)) begin
      r.have_v  = 1'b1;
      r.verdict = jmsc_pkg::VERDICT_BAD;
    end else if (c == jmsc_pkg::CODE_EOI) begin
      r.have_v  = 1'b1;
      r.verdict = lst ? jmsc_pkg::VERDICT_GOOD : jmsc_pkg::VERDICT_EXTRA;
    end else if (c == jmsc_pkg::CODE_SOI || c == jmsc_pkg::CODE_TEM) begin
      r.phase = jmsc_pkg::PH_PREFIX;
    end else if (c == jmsc_pkg::CODE_SOS) begin
      if (skip) begin
        r.phase      = jmsc_pkg::PH_SKIPALL;
        r.enter_skip = 1'b1;
      end else begin
        r.in_scan = 1'b1;
      end
    end
    return r;
  endfunction

  assign b        = s1_item.data_byte;
  assign last     = s1_item.last_byte;
  assign seg_len  = {len_hi_r, b};
  assign skip_dec = skip_left_r - 16'd1;

  always_comb begin
    cr_used = 1'b0;
    cr      = on_code(b, last, skip_entropy, 1'b0);
    unique case (phase_r)
      jmsc_pkg::PH_CODE: begin
        cr      = on_code(b, last, skip_entropy, in_scan_r);
        cr_used = 1'b1;
      end
      jmsc_pkg::PH_ENT_FF: begin
        cr_used = !(b == jmsc_pkg::BYTE_ZERO || jmsc_pkg::is_rst_code(b) ||
                    b == jmsc_pkg::BYTE_FF);
      end
      jmsc_pkg::PH_FILL: begin
        cr_used = (b != jmsc_pkg::BYTE_FF);
      end
      default: begin
        cr_used = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    in_scan_nxt   = in_scan_r;
    len_hi_nxt    = len_hi_r;
    skip_left_nxt = skip_left_r;
    prev_nxt      = prev_r;
    have_v        = 1'b0;
    verdict       = jmsc_pkg::VERDICT_GOOD;
    tail_hi       = jmsc_pkg::BYTE_FF;
    tail_lo       = jmsc_pkg::CODE_SOS;

    unique case (phase_r)
      jmsc_pkg::PH_PREFIX: begin
        if (b != jmsc_pkg::BYTE_FF) begin
          have_v  = 1'b1;
          verdict = jmsc_pkg::VERDICT_BAD;
        end else begin
          phase_nxt = jmsc_pkg::PH_CODE;
        end
      end
      jmsc_pkg::PH_LEN_HI: begin
        len_hi_nxt = b;
        phase_nxt  = jmsc_pkg::PH_LEN_LO;
      end
      jmsc_pkg::PH_LEN_LO: begin
        if (seg_len > 16'd2) begin
          skip_left_nxt = seg_len - 16'd2;
          phase_nxt     = jmsc_pkg::PH_SKIP;
        end else begin
          phase_nxt = in_scan_r ? jmsc_pkg::PH_ENTROPY : jmsc_pkg::PH_PREFIX;
        end
      end
      jmsc_pkg::PH_SKIP: begin
        skip_left_nxt = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_nxt = in_scan_r ? jmsc_pkg::PH_ENTROPY : jmsc_pkg::PH_PREFIX;
        end
      end
      jmsc_pkg::PH_ENTROPY: begin
        if (b == jmsc_pkg::BYTE_FF) begin
          phase_nxt = jmsc_pkg::PH_ENT_FF;
        end
      end
      jmsc_pkg::PH_ENT_FF: begin
        if (b == jmsc_pkg::BYTE_ZERO || jmsc_pkg::is_rst_code(b)) begin
          phase_nxt = jmsc_pkg::PH_ENTROPY;
        end else if (b == jmsc_pkg::BYTE_FF) begin
          phase_nxt = jmsc_pkg::PH_FILL;
        end
      end
      jmsc_pkg::PH_SKIPALL: begin
        prev_nxt = b;
        tail_hi  = prev_r;
        tail_lo  = b;
      end
      default: begin
      end
    endcase

    if (cr_used) begin
      have_v      = cr.have_v;
      verdict     = cr.verdict;
      phase_nxt   = cr.phase;
      in_scan_nxt = cr.in_scan;
      if (cr.enter_skip) begin
        prev_nxt = jmsc_pkg::CODE_SOS;
      end
    end

    if (phase_nxt != jmsc_pkg::PH_DONE && !have_v && last) begin
      have_v  = 1'b1;
      verdict = (phase_nxt == jmsc_pkg::PH_SKIPALL) ?
                jmsc_pkg::judge_tail(tail_hi, tail_lo) : jmsc_pkg::VERDICT_SHORT;
    end

    if (have_v) begin
      phase_nxt = jmsc_pkg::PH_DONE;
    end

    if (last) begin
      phase_nxt     = jmsc_pkg::PH_PREFIX;
      in_scan_nxt   = 1'b0;
      len_hi_nxt    = '0;
      skip_left_nxt = '0;
      prev_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= jmsc_pkg::PH_PREFIX;
      in_scan_r   <= 1'b0;
      len_hi_r    <= '0;
      skip_left_r <= '0;
      prev_r      <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      in_scan_r   <= in_scan_nxt;
      len_hi_r    <= len_hi_nxt;
      skip_left_r <= skip_left_nxt;
      prev_r      <= prev_nxt;
    end
  end

  assign res.valid   = have_v;
  assign res.verdict = verdict;

endmodule

[design/jmsc_out_reg.sv]
// Result register of the JPEG marker stream checker, holding one verdict request.
// Depends on jmsc_pkg for the result type.
module jmsc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  jmsc_pkg::result_t res,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_verdict
);

  logic       valid_r, valid_nxt;
  logic [1:0] verdict_r;
  logic       load;

  assign adv  = s1_valid && (!valid_r || !out_stall);
  assign load = adv && res.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= res.verdict;
    end
  end

  assign out_valid   = valid_r;
  assign out_verdict = verdict_r;

endmodule

[design/jpeg_marker_stream_checker.sv]
// JPEG marker stream checker: one file byte per request, at most one verdict per file.
// A verdict passes through the input register and then the result register before out_valid.
// Throughput: one byte per cycle while in_stall is low; the parser state updates once per byte.
// in_stall rises only while the result register holds a stalled verdict.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to the
// marker prefix phase and clears skip_entropy.
module jpeg_marker_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_skip_entropy
);

  jmsc_pkg::item_t   in_item;
  jmsc_pkg::item_t   s1_item;
  jmsc_pkg::result_t res;
  logic              s1_valid;
  logic              adv;
  logic              skip_entropy_r;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;
  assign cfg_ready         = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_entropy_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      skip_entropy_r <= cfg_skip_entropy;
    end
  end

  jmsc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  jmsc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .s1_item      (s1_item),
    .skip_entropy (skip_entropy_r),
    .res          (res)
  );

  jmsc_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .res         (res),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict)
  );

endmodule

[design/jmsc_checker.sv]
// Port-level checks for the JPEG marker stream checker, bound to the top level.
// Depends only on the top level's port names.
module jmsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict))
    else $error("stalled verdict request changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("stalled byte request changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled verdict");

  a_verdict_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("verdict without an accepted byte two cycles earlier");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind jpeg_marker_stream_checker jmsc_checker u_jmsc_checker (.*);
